>>> src/sqd_pkg.sv
`timescale 1ns / 1ps

package sqd_pkg;

   // Size of the dispatcher.
   localparam int NUM_QUEUES  = 5;
   localparam int QUEUE_DEPTH = 16;

   // Derived widths.
   localparam int SRV_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = $clog2(NUM_QUEUES * QUEUE_DEPTH);
   localparam int MASK_W = 5;

   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

   // Request and response payloads.
   typedef struct packed {
      logic       func;
      logic       arrival_valid;
      logic       is_vip;
      logic [7:0] service_minutes;
      logic [2:0] queue_select;
   } req_type;

   typedef struct packed {
      logic [2:0]  assigned_queue;
      logic        arrival_placed;
      logic        system_busy;
      logic [4:0]  started_mask;
      logic [4:0]  finished_mask;
      logic [47:0] vip_wait_total;
      logic [31:0] vip_started_count;
      logic [47:0] ordinary_wait_total;
      logic [31:0] ordinary_started_count;
      logic [31:0] queue_served_count;
      logic [47:0] queue_ordinary_wait_total;
      logic [31:0] queue_ordinary_started_count;
   } rsp_type;

   // One entry of the job store.
   typedef struct packed {
      logic [31:0] arrival;
      logic [7:0]  service;
      logic        vip;
   } job_type;

   typedef logic [FILL_W-1:0] fill_type;

   // Saturating accumulate of a wait into a 48-bit sum.
   function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
      logic [48:0] sum;
      sum = {1'b0, a} + {17'b0, b};
      return (sum >= {1'b0, MAX48}) ? MAX48 : sum[47:0];
   endfunction

   // Saturating increment of a 32-bit count.
   function automatic logic [31:0] sat_inc32(input logic [31:0] a);
      return (a == MAX32) ? MAX32 : a + 32'd1;
   endfunction

endpackage

>>> src/sqd_pick.sv
`timescale 1ns / 1ps

module sqd_pick (
   input  sqd_pkg::fill_type               fill [sqd_pkg::NUM_QUEUES],
   input  logic [sqd_pkg::NUM_QUEUES-1:0]  busy,
   input  logic                            is_vip,
   input  logic [2:0]                      first_cfg,
   output logic [sqd_pkg::SRV_W-1:0]       best
);

   logic [2:0]                    first_q;
   logic [sqd_pkg::FILL_W:0]      best_len;
   logic [sqd_pkg::FILL_W:0]      len;
   logic                          found;

   // Lowest eligible queue, clamped to the last queue.
   always_comb begin
      if (is_vip) begin
         first_q = 3'd0;
      end else if (32'(first_cfg) >= sqd_pkg::NUM_QUEUES) begin
         first_q = 3'(sqd_pkg::NUM_QUEUES - 1);
      end else begin
         first_q = first_cfg;
      end
   end

   // Scan for the smallest occupancy; the lowest index wins ties.
   always_comb begin
      best     = '0;
      best_len = '0;
      found    = 1'b0;
      len      = '0;
      for (int i = 0; i < sqd_pkg::NUM_QUEUES; i++) begin
         len = {1'b0, fill[i]} + {{sqd_pkg::FILL_W{1'b0}}, busy[i]};
         if ((3'(i) >= first_q) && (!found || (len < best_len))) begin
            found    = 1'b1;
            best_len = len;
            best     = sqd_pkg::SRV_W'(i);
         end
      end
   end

endmodule

>>> src/shortest_queue_dispatch_servers.sv
`timescale 1ns / 1ps

// Join-shortest-queue dispatcher with five queues, each feeding one server. A tick
// request (func 0) places an optional arriving job into the eligible queue with the
// least occupancy, then visits servers 0 to 4 in turn: an idle server pulls its queue
// head from the job store, and every busy server counts down. A tick passes an
// arrival state, then a read state and an update state per server, then a result
// state; the read states come from the single read port of the job store, through
// which each server's head is fetched in turn. A statistics read (func 1) changes
// no state. Values of the ordinary_first_queue register above 4 act as 4. The user
// writes it over the csr port only while no request is in flight (not enforced).
module shortest_queue_dispatch_servers (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sqd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sqd_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_data
);

   localparam int N = sqd_pkg::NUM_QUEUES;
   localparam int D = sqd_pkg::QUEUE_DEPTH;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ARRIVE = 5'b00010,
      ST_SRV_RD = 5'b00100,
      ST_SRV_EX = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   sqd_pkg::req_type req_ff, req_in;
   logic [2:0] cfg_ff, cfg_in;
   logic [sqd_pkg::SRV_W-1:0] srv_ff, srv_in;
   logic start_ff, start_in;

   logic [sqd_pkg::PTR_W-1:0] head_ff [N];
   logic [sqd_pkg::PTR_W-1:0] head_in [N];
   logic [sqd_pkg::PTR_W-1:0] tail_ff [N];
   logic [sqd_pkg::PTR_W-1:0] tail_in [N];
   sqd_pkg::fill_type fill_ff [N];
   sqd_pkg::fill_type fill_in [N];
   logic [N-1:0] busy_ff, busy_in;
   logic [N-1:0] vipsrv_ff, vipsrv_in;
   logic [7:0] remain_ff [N];
   logic [7:0] remain_in [N];

   logic [31:0] tick_ff, tick_in;
   logic [47:0] vip_wait_ff, vip_wait_in;
   logic [31:0] vip_cnt_ff, vip_cnt_in;
   logic [47:0] ord_wait_ff, ord_wait_in;
   logic [31:0] ord_cnt_ff, ord_cnt_in;
   logic [47:0] q_wait_ff [N];
   logic [47:0] q_wait_in [N];
   logic [31:0] q_cnt_ff [N];
   logic [31:0] q_cnt_in [N];
   logic [31:0] done_cnt_ff [N];
   logic [31:0] done_cnt_in [N];

   logic [2:0] assigned_ff, assigned_in;
   logic placed_ff, placed_in;
   logic sysbusy_ff, sysbusy_in;
   logic [N-1:0] started_ff, started_in;
   logic [N-1:0] finished_ff, finished_in;

   logic rsp_valid_ff, rsp_valid_in;
   sqd_pkg::rsp_type rsp_ff, rsp_in;

   // Job store, one synchronous read port and one write port.
   sqd_pkg::job_type job_mem [N * D];
   sqd_pkg::job_type rdata_ff;
   logic mem_we, mem_re;
   logic [sqd_pkg::ADDR_W-1:0] wr_addr, rd_addr;
   sqd_pkg::job_type wr_data;

   logic [sqd_pkg::SRV_W-1:0] pick_q;
   logic [7:0] svc;
   logic [31:0] wait_t;
   logic [7:0] rem_eff;
   logic [7:0] rem_dec;
   logic [sqd_pkg::SRV_W-1:0] sel_idx;
   logic sel_ok;

   sqd_pick u_pick (
      .fill      (fill_ff),
      .busy      (busy_ff),
      .is_vip    (req_ff.is_vip),
      .first_cfg (cfg_ff),
      .best      (pick_q)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   assign svc     = (req_ff.service_minutes == 8'd0) ? 8'd1 : req_ff.service_minutes;
   assign wr_addr = sqd_pkg::ADDR_W'(32'(pick_q) * D + 32'(tail_ff[pick_q]));
   assign wr_data = '{arrival: tick_ff, service: svc, vip: req_ff.is_vip};
   assign rd_addr = sqd_pkg::ADDR_W'(32'(srv_ff) * D + 32'(head_ff[srv_ff]));
   assign mem_re  = (state_ff == ST_SRV_RD);
   assign wait_t  = tick_ff - rdata_ff.arrival;
   assign sel_ok  = 32'(req_ff.queue_select) < N;
   assign sel_idx = sqd_pkg::SRV_W'(req_ff.queue_select);

   // Job store access.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         job_mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rdata_ff <= job_mem[rd_addr];
      end
   end

   // Sequencer and state update.
   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      cfg_in      = cfg_ff;
      srv_in      = srv_ff;
      start_in    = start_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      busy_in     = busy_ff;
      vipsrv_in   = vipsrv_ff;
      remain_in   = remain_ff;
      tick_in     = tick_ff;
      vip_wait_in = vip_wait_ff;
      vip_cnt_in  = vip_cnt_ff;
      ord_wait_in = ord_wait_ff;
      ord_cnt_in  = ord_cnt_ff;
      q_wait_in   = q_wait_ff;
      q_cnt_in    = q_cnt_ff;
      done_cnt_in = done_cnt_ff;
      assigned_in = assigned_ff;
      placed_in   = placed_ff;
      sysbusy_in  = sysbusy_ff;
      started_in  = started_ff;
      finished_in = finished_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in      = rsp_ff;
      mem_we      = 1'b0;
      rem_eff     = '0;
      rem_dec     = '0;

      // Configuration transfer.
      if (csr_valid) begin
         cfg_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               srv_in      = '0;
               assigned_in = '0;
               placed_in   = 1'b0;
               sysbusy_in  = 1'b0;
               started_in  = '0;
               finished_in = '0;
               state_in    = req_data.func ? ST_DONE : ST_ARRIVE;
            end
         end

         // Place the arrival in the least occupied eligible queue.
         ST_ARRIVE: begin
            if (req_ff.arrival_valid) begin
               assigned_in = 3'(pick_q);
               if (32'(fill_ff[pick_q]) < D) begin
                  mem_we           = 1'b1;
                  tail_in[pick_q]  = (32'(tail_ff[pick_q]) == D - 1) ? '0 :
                                     tail_ff[pick_q] + 1'b1;
                  fill_in[pick_q]  = fill_ff[pick_q] + 1'b1;
                  placed_in        = 1'b1;
               end
            end
            state_in = ST_SRV_RD;
         end

         // Fetch this server's queue head and decide whether the server starts a job.
         ST_SRV_RD: begin
            start_in = !busy_ff[srv_ff] && (fill_ff[srv_ff] != '0);
            state_in = ST_SRV_EX;
         end

         // Start and count down this server.
         ST_SRV_EX: begin
            rem_eff = remain_ff[srv_ff];
            if (start_ff) begin
               head_in[srv_ff]    = (32'(head_ff[srv_ff]) == D - 1) ? '0 :
                                    head_ff[srv_ff] + 1'b1;
               fill_in[srv_ff]    = fill_ff[srv_ff] - 1'b1;
               started_in[srv_ff] = 1'b1;
               rem_eff            = rdata_ff.service;
               if (rdata_ff.vip) begin
                  vip_wait_in = sqd_pkg::sat_add48(vip_wait_ff, wait_t);
                  vip_cnt_in  = sqd_pkg::sat_inc32(vip_cnt_ff);
               end else begin
                  ord_wait_in      = sqd_pkg::sat_add48(ord_wait_ff, wait_t);
                  ord_cnt_in       = sqd_pkg::sat_inc32(ord_cnt_ff);
                  q_wait_in[srv_ff] = sqd_pkg::sat_add48(q_wait_ff[srv_ff], wait_t);
                  q_cnt_in[srv_ff]  = sqd_pkg::sat_inc32(q_cnt_ff[srv_ff]);
               end
            end
            if (start_ff || busy_ff[srv_ff]) begin
               sysbusy_in = 1'b1;
               rem_dec    = (rem_eff != 8'd0) ? rem_eff - 8'd1 : 8'd0;
               remain_in[srv_ff] = rem_dec;
               busy_in[srv_ff]   = 1'b1;
               vipsrv_in[srv_ff] = start_ff ? rdata_ff.vip : vipsrv_ff[srv_ff];
               if (rem_dec == 8'd0) begin
                  busy_in[srv_ff]     = 1'b0;
                  vipsrv_in[srv_ff]   = 1'b0;
                  finished_in[srv_ff] = 1'b1;
                  done_cnt_in[srv_ff] = sqd_pkg::sat_inc32(done_cnt_ff[srv_ff]);
               end
            end
            if (32'(srv_ff) == N - 1) begin
               state_in = ST_DONE;
            end else begin
               srv_in   = srv_ff + 1'b1;
               state_in = ST_SRV_RD;
            end
         end

         // Load the result register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in = '0;
               rsp_in.vip_wait_total         = vip_wait_ff;
               rsp_in.vip_started_count      = vip_cnt_ff;
               rsp_in.ordinary_wait_total    = ord_wait_ff;
               rsp_in.ordinary_started_count = ord_cnt_ff;
               if (req_ff.func) begin
                  if (sel_ok) begin
                     rsp_in.queue_served_count           = done_cnt_ff[sel_idx];
                     rsp_in.queue_ordinary_wait_total    = q_wait_ff[sel_idx];
                     rsp_in.queue_ordinary_started_count = q_cnt_ff[sel_idx];
                  end
               end else begin
                  rsp_in.assigned_queue = assigned_ff;
                  rsp_in.arrival_placed = placed_ff;
                  rsp_in.system_busy    = sysbusy_ff;
                  rsp_in.started_mask   = sqd_pkg::MASK_W'(started_ff);
                  rsp_in.finished_mask  = sqd_pkg::MASK_W'(finished_ff);
                  tick_in = tick_ff + 32'd1;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= 3'd2;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= '0;
         vipsrv_ff    <= '0;
         tick_ff      <= 32'd1;
         vip_wait_ff  <= '0;
         vip_cnt_ff   <= '0;
         ord_wait_ff  <= '0;
         ord_cnt_ff   <= '0;
         for (int i = 0; i < N; i++) begin
            head_ff[i]     <= '0;
            tail_ff[i]     <= '0;
            fill_ff[i]     <= '0;
            remain_ff[i]   <= '0;
            q_wait_ff[i]   <= '0;
            q_cnt_ff[i]    <= '0;
            done_cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
         vipsrv_ff    <= vipsrv_in;
         tick_ff      <= tick_in;
         vip_wait_ff  <= vip_wait_in;
         vip_cnt_ff   <= vip_cnt_in;
         ord_wait_ff  <= ord_wait_in;
         ord_cnt_ff   <= ord_cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         remain_ff    <= remain_in;
         q_wait_ff    <= q_wait_in;
         q_cnt_ff     <= q_cnt_in;
         done_cnt_ff  <= done_cnt_in;
      end
   end

   // Per-request working registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      srv_ff      <= srv_in;
      start_ff    <= start_in;
      assigned_ff <= assigned_in;
      placed_ff   <= placed_in;
      sysbusy_ff  <= sysbusy_in;
      started_ff  <= started_in;
      finished_ff <= finished_in;
      rsp_ff      <= rsp_in;
   end

endmodule

>>> tb/shortest_queue_dispatch_servers_test.sv
`timescale 1ns / 1ps

module shortest_queue_dispatch_servers_test;

   localparam int CYCLE_LIMIT = 3000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   sqd_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   sqd_pkg::rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [2:0] csr_data;

   shortest_queue_dispatch_servers dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   // Dispatcher mirror: waiting jobs per queue, server state and statistics.
   sqd_pkg::job_type waiting_jobs[sqd_pkg::NUM_QUEUES][$];
   logic        srv_busy[sqd_pkg::NUM_QUEUES];
   logic [7:0]  srv_left[sqd_pkg::NUM_QUEUES];
   logic [31:0] tick_now;
   logic [47:0] vip_wait_sum;
   logic [31:0] vip_starts;
   logic [47:0] ord_wait_sum;
   logic [31:0] ord_starts;
   logic [47:0] queue_ord_wait[sqd_pkg::NUM_QUEUES];
   logic [31:0] queue_ord_starts[sqd_pkg::NUM_QUEUES];
   logic [31:0] srv_completed[sqd_pkg::NUM_QUEUES];
   logic [2:0]  ord_first_q;

   sqd_pkg::rsp_type pending_rsp[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          quiet_mode = 0;
   bit          rsp_hold = 0;
   bit          rsp_moved = 0;

   always #5 clock = ~clock;

   function automatic logic [47:0] add_wait_sat(logic [47:0] a, logic [31:0] b);
      return ({16'b0, b} >= sqd_pkg::MAX48 - a) ? sqd_pkg::MAX48 : a + {16'b0, b};
   endfunction

   function automatic logic [31:0] inc_sat(logic [31:0] a);
      return (a == sqd_pkg::MAX32) ? sqd_pkg::MAX32 : a + 32'd1;
   endfunction

   // Works out the response to one request and advances the mirror.
   function automatic sqd_pkg::rsp_type dispatch_step(sqd_pkg::req_type r);
      sqd_pkg::rsp_type o;
      int unsigned first_q, best, best_len, occ;
      sqd_pkg::job_type j;
      logic [31:0] waited;
      o = '0;
      if (r.func) begin
         if (r.queue_select < sqd_pkg::NUM_QUEUES) begin
            o.queue_served_count           = srv_completed[r.queue_select];
            o.queue_ordinary_wait_total    = queue_ord_wait[r.queue_select];
            o.queue_ordinary_started_count = queue_ord_starts[r.queue_select];
         end
      end else begin
         // Join the shortest eligible queue; the lowest index wins ties.
         if (r.arrival_valid) begin
            first_q = r.is_vip ? 0 : ord_first_q;
            if (first_q >= sqd_pkg::NUM_QUEUES) first_q = sqd_pkg::NUM_QUEUES - 1;
            best = first_q;
            best_len = waiting_jobs[first_q].size() + srv_busy[first_q];
            for (int i = first_q + 1; i < sqd_pkg::NUM_QUEUES; i++) begin
               occ = waiting_jobs[i].size() + srv_busy[i];
               if (occ < best_len) begin
                  best_len = occ;
                  best = i;
               end
            end
            o.assigned_queue = 3'(best);
            if (waiting_jobs[best].size() < sqd_pkg::QUEUE_DEPTH) begin
               j.arrival = tick_now;
               j.service = (r.service_minutes == 0) ? 8'd1 : r.service_minutes;
               j.vip = r.is_vip;
               waiting_jobs[best].push_back(j);
               o.arrival_placed = 1'b1;
            end
         end
         // Servers in index order: start a waiting job, then count down.
         for (int i = 0; i < sqd_pkg::NUM_QUEUES; i++) begin
            if (!srv_busy[i] && waiting_jobs[i].size() > 0) begin
               j = waiting_jobs[i].pop_front();
               waited = tick_now - j.arrival;
               srv_busy[i] = 1'b1;
               srv_left[i] = j.service;
               o.started_mask[i] = 1'b1;
               if (j.vip) begin
                  vip_wait_sum = add_wait_sat(vip_wait_sum, waited);
                  vip_starts = inc_sat(vip_starts);
               end else begin
                  ord_wait_sum = add_wait_sat(ord_wait_sum, waited);
                  ord_starts = inc_sat(ord_starts);
                  queue_ord_wait[i] = add_wait_sat(queue_ord_wait[i], waited);
                  queue_ord_starts[i] = inc_sat(queue_ord_starts[i]);
               end
            end
            if (srv_busy[i]) begin
               o.system_busy = 1'b1;
               if (srv_left[i] > 0) srv_left[i]--;
               if (srv_left[i] == 0) begin
                  srv_busy[i] = 1'b0;
                  o.finished_mask[i] = 1'b1;
                  srv_completed[i] = inc_sat(srv_completed[i]);
               end
            end
         end
         tick_now++;
      end
      o.vip_wait_total         = vip_wait_sum;
      o.vip_started_count      = vip_starts;
      o.ordinary_wait_total    = ord_wait_sum;
      o.ordinary_started_count = ord_starts;
      return o;
   endfunction

   function automatic void check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         error_count++;
      end
   endfunction

   // Compare every response transfer with the oldest prediction.
   always @(posedge clock) begin
      sqd_pkg::rsp_type e;
      rsp_moved <= !reset && rsp_valid && rsp_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response transfer with no request outstanding");
            error_count++;
         end else begin
            e = pending_rsp.pop_front();
            check_field("assigned_queue", e.assigned_queue, rsp_data.assigned_queue);
            check_field("arrival_placed", e.arrival_placed, rsp_data.arrival_placed);
            check_field("system_busy", e.system_busy, rsp_data.system_busy);
            check_field("started_mask", e.started_mask, rsp_data.started_mask);
            check_field("finished_mask", e.finished_mask, rsp_data.finished_mask);
            check_field("vip_wait_total", e.vip_wait_total, rsp_data.vip_wait_total);
            check_field("vip_started_count", e.vip_started_count,
                        rsp_data.vip_started_count);
            check_field("ordinary_wait_total", e.ordinary_wait_total,
                        rsp_data.ordinary_wait_total);
            check_field("ordinary_started_count", e.ordinary_started_count,
                        rsp_data.ordinary_started_count);
            check_field("queue_served_count", e.queue_served_count,
                        rsp_data.queue_served_count);
            check_field("queue_ordinary_wait_total", e.queue_ordinary_wait_total,
                        rsp_data.queue_ordinary_wait_total);
            check_field("queue_ordinary_started_count", e.queue_ordinary_started_count,
                        rsp_data.queue_ordinary_started_count);
         end
      end
   end

   // Response side: a random stall after each transfer outside quiet mode, or a long hold when asked.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_moved && !quiet_mode) stall_left = $urandom_range(0, 12);
         if (rsp_hold) begin
            rsp_ready = 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("shortest_queue_dispatch_servers test failed");
         $finish;
      end
   end

   // Sends one request; returns at the falling edge after its transfer.
   task automatic send_req(sqd_pkg::req_type r);
      int gap;
      gap = quiet_mode ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(dispatch_step(r));
      @(negedge clock);
   endtask

   task automatic send_tick(bit arrive, bit vip, logic [7:0] svc);
      sqd_pkg::req_type r;
      r = '0;
      r.arrival_valid = arrive;
      r.is_vip = vip;
      r.service_minutes = svc;
      r.queue_select = 3'($urandom_range(0, 7));
      send_req(r);
   endtask

   task automatic send_read(logic [2:0] sel);
      sqd_pkg::req_type r;
      r = '0;
      r.func = 1'b1;
      r.arrival_valid = 1'($urandom_range(0, 1));
      r.is_vip = 1'($urandom_range(0, 1));
      r.service_minutes = 8'($urandom_range(0, 255));
      r.queue_select = sel;
      send_req(r);
   endtask

   // Waits out all responses, then writes the first ordinary queue.
   task automatic write_first_queue(logic [2:0] val);
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_data = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      ord_first_q = val;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_random_req();
      int pick;
      logic [7:0] svc;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         send_read(3'($urandom_range(0, 7)));
      end else begin
         svc = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 24));
         send_tick(pick >= 22, 1'($urandom_range(0, 1)), svc);
      end
   endtask

   // Extremes of the fields, every selector, zero service and a full queue.
   task automatic test_directed();
      send_tick(1'b0, 1'b0, 8'd0);
      send_tick(1'b1, 1'b1, 8'd0);
      send_tick(1'b1, 1'b0, 8'd255);
      send_tick(1'b1, 1'b1, 8'd1);
      for (int s = 0; s < 8; s++) send_read(3'(s));
      write_first_queue(3'd7);
      for (int k = 0; k < 18; k++) send_tick(1'b1, 1'b0, 8'd30);
      send_read(3'd4);
   endtask

   // Every register value, with a burst of traffic under each.
   task automatic test_config_sweep();
      for (int v = 0; v < 8; v++) begin
         write_first_queue(3'(v));
         repeat (25) send_random_req();
      end
   endtask

   // The receiver holds off while requests keep coming, so the block stalls.
   task automatic test_backpressure();
      fork
         begin
            rsp_hold = 1'b1;
            repeat (400) @(negedge clock);
            rsp_hold = 1'b0;
         end
         repeat (40) send_tick(1'b1, 1'($urandom_range(0, 1)), 8'($urandom_range(1, 8)));
      join
   endtask

   // The sender pauses until all responses are in, then resumes.
   task automatic test_drain_pause();
      repeat (20) send_random_req();
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (20) send_random_req();
   endtask

   task automatic test_random();
      for (int blk = 0; blk < 12; blk++) begin
         write_first_queue(3'($urandom_range(0, 7)));
         quiet_mode = (blk % 4 == 3);
         repeat (125) send_random_req();
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      for (int i = 0; i < sqd_pkg::NUM_QUEUES; i++) begin
         waiting_jobs[i] = {};
         srv_busy[i] = 1'b0;
         srv_left[i] = '0;
         queue_ord_wait[i] = '0;
         queue_ord_starts[i] = '0;
         srv_completed[i] = '0;
      end
      tick_now = 32'd1;
      vip_wait_sum = '0;
      vip_starts = '0;
      ord_wait_sum = '0;
      ord_starts = '0;
      ord_first_q = 3'd2;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_config_sweep();
      test_backpressure();
      test_drain_pause();
      test_random();

      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (error_count == 0) begin
         $display("shortest_queue_dispatch_servers test passed");
      end else begin
         $display("shortest_queue_dispatch_servers test failed");
      end
      $finish;
   end

endmodule
